// ===== sv/drp_pkg.sv =====
// ----------------------------------------------------------------------------
// drp_pkg: shared definitions for the disparity reprojection unit
// Register indexes, field widths, reset values and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int IMG_W_W    = 13;
    localparam int CAM_W      = 20;
    localparam int BASE_W     = 16;
    localparam int OFF_W      = 21;

    // Bits retired per divider cycle
    localparam int DIV_BITS = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FWD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SIDE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_UP    = 3'd7;

    // Register reset values
    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [CAM_W-1:0]   RST_FOCAL_LENGTH = 20'd102092;
    localparam logic [CAM_W-1:0]   RST_CENTER_COL   = 20'd80762;
    localparam logic [CAM_W-1:0]   RST_CENTER_ROW   = 20'd52523;
    localparam logic [BASE_W-1:0]  RST_BASELINE     = 16'd4915;
    localparam logic [OFF_W-1:0]   RST_OFFSET_FWD   = 21'd18350;
    localparam logic [OFF_W-1:0]   RST_OFFSET_SIDE  = 21'd2458;
    localparam logic [OFF_W-1:0]   RST_OFFSET_UP    = 21'd18350;

    // Range tracker reset values
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // Output axis codes
    localparam logic [1:0] AXIS_FWD  = 2'd0;
    localparam logic [1:0] AXIS_SIDE = 2'd1;
    localparam logic [1:0] AXIS_UP   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;        // input channel ready
        logic       norm_fix;    // load d for a trivial normalization
        logic       norm_start;  // start the normalization divide
        logic       norm_load;   // round and load d from the divider
        logic       mul;         // register the axis product
        logic       prep;        // form the axis dividend
        logic       div_start;   // start the axis divide
        logic       store;       // finish the axis and hold it
        logic       out_load;    // move the point to the output register
        logic [1:0] axis;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic norm_trivial;
        logic div_done;
        logic d_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/drp_stream_if.sv =====
// ----------------------------------------------------------------------------
// drp_stream_if: valid/ready channels of the disparity reprojection unit
// Pixel request channel and point request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface drp_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [drp_pkg::PIX_W-1:0]  disparity;
    logic                       frame_end;

    modport source (output valid, mode, disparity, frame_end, input ready);
    modport sink   (input valid, mode, disparity, frame_end, output ready);
endinterface

interface drp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [drp_pkg::OUT_W-1:0]  point_fwd;
    logic signed [drp_pkg::OUT_W-1:0]  point_side;
    logic signed [drp_pkg::OUT_W-1:0]  point_up;

    modport source (output valid, point_fwd, point_side, point_up, input ready);
    modport sink   (input valid, point_fwd, point_side, point_up, output ready);
endinterface

`default_nettype wire

// ===== sv/drp_div.sv =====
// ----------------------------------------------------------------------------
// drp_div: iterative unsigned divider by an 8-bit divisor
// Restoring division, DIV_BITS quotient bits per cycle while busy; done is
// high for a single cycle once the last step is registered, with quotient and remainder held.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_div #(
    parameter int DIVIDEND_W = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [DIVIDEND_W-1:0]             dividend,
    input  wire logic [drp_pkg::PIX_W-1:0]         divisor,
    output logic                                   done,
    output logic [DIVIDEND_W-1:0]                  quotient,
    output logic [drp_pkg::PIX_W-1:0]              remainder
);

    localparam int STEPS = DIVIDEND_W / drp_pkg::DIV_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int PW    = drp_pkg::PIX_W;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [PW-1:0]         rem_reg, rem_next;
    logic [PW-1:0]         dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Retire DIV_BITS quotient bits
    always_comb
    begin
        logic [PW:0] r9;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < drp_pkg::DIV_BITS; i++)
        begin
            r9       = {rem_next, quo_next[DIVIDEND_W-1]};
            quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
            if (r9 >= {1'b0, dsr_reg})
            begin
                r9          = r9 - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = r9[PW-1:0];
        end
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/drp_ctrl.sv =====
// ----------------------------------------------------------------------------
// drp_ctrl: sequencer of the disparity reprojection unit
// Takes pixels, then steps the datapath through normalization and the
// three axis divides of a convert pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_mode,
    input  wire drp_pkg::status_t sts,
    output drp_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_NWAIT,
        S_CHK,
        S_MUL,
        S_PREP,
        S_DIV,
        S_DWAIT,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_mode)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                state_next = sts.norm_trivial ? S_CHK : S_NWAIT;
            end
            S_NWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                axis_next  = drp_pkg::AXIS_FWD;
                state_next = sts.d_zero ? S_IDLE : S_MUL;
            end
            S_MUL:   state_next = S_PREP;
            S_PREP:  state_next = S_DIV;
            S_DIV:   state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    if (axis_reg == drp_pkg::AXIS_UP)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= drp_pkg::AXIS_FWD;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Decode commands
    always_comb
    begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.take       = (state_reg == S_IDLE);
        cmd.norm_fix   = (state_reg == S_NORM) && sts.norm_trivial;
        cmd.norm_start = (state_reg == S_NORM) && !sts.norm_trivial;
        cmd.norm_load  = (state_reg == S_NWAIT) && sts.div_done;
        cmd.mul        = (state_reg == S_MUL);
        cmd.prep       = (state_reg == S_PREP);
        cmd.div_start  = (state_reg == S_DIV);
        cmd.store      = (state_reg == S_DWAIT) && sts.div_done;
        cmd.out_load   = (state_reg == S_OUT) && sts.out_free;
    end

endmodule

`default_nettype wire

// ===== sv/drp_datapath.sv =====
// ----------------------------------------------------------------------------
// drp_datapath: registers and arithmetic of the disparity reprojection unit
// Configuration registers, range tracker, pixel counters, normalization,
// shared multiplier and divider, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_datapath #(
    parameter int MAX_WIDTH  = drp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = drp_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [drp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [drp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_mode,
    input  wire logic [drp_pkg::PIX_W-1:0]           in_disparity,
    input  wire logic                                in_frame_end,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic signed [drp_pkg::OUT_W-1:0]         out_fwd,
    output logic signed [drp_pkg::OUT_W-1:0]         out_side,
    output logic signed [drp_pkg::OUT_W-1:0]         out_up,
    input  wire drp_pkg::cmd_t                       cmd,
    output drp_pkg::status_t                         sts
);

    localparam int PXW  = drp_pkg::PIX_W;
    localparam int OW   = drp_pkg::OUT_W;
    localparam int OFW  = drp_pkg::OFF_W;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int PW   = (CW > RW) ? CW : RW;
    localparam int CMPW = (CW + 1 > drp_pkg::IMG_W_W) ? CW + 1 : drp_pkg::IMG_W_W;
    localparam int DW   = ((PW + 8 > drp_pkg::CAM_W) ? PW + 8 : drp_pkg::CAM_W) + 1;
    localparam int MW   = DW + drp_pkg::BASE_W + 1;
    localparam int DVW  = MW - 7;
    localparam int DVP  = ((DVW + drp_pkg::DIV_BITS - 1) / drp_pkg::DIV_BITS)
                          * drp_pkg::DIV_BITS;
    localparam int SW   = DVW + 2;

    // Configuration registers
    logic [drp_pkg::IMG_W_W-1:0] image_width_reg;
    logic [drp_pkg::CAM_W-1:0]   focal_length_reg;
    logic [drp_pkg::CAM_W-1:0]   center_col_reg;
    logic [drp_pkg::CAM_W-1:0]   center_row_reg;
    logic [drp_pkg::BASE_W-1:0]  baseline_reg;
    logic [OFW-1:0]              offset_fwd_reg;
    logic [OFW-1:0]              offset_side_reg;
    logic [OFW-1:0]              offset_up_reg;

    // Frame state
    logic [PXW-1:0] lowest_reg, highest_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;

    // Working copies of a convert pixel
    logic [PXW-1:0] pix_w_reg, lo_w_reg, hi_w_reg;
    logic [CW-1:0]  col_w_reg;
    logic [RW-1:0]  row_w_reg;

    // Arithmetic registers
    logic [PXW-1:0]       d_reg;
    logic signed [MW-1:0] prod_reg;
    logic [DVW-1:0]       dvd_reg;
    logic                 neg_reg;
    logic [OW-1:0]        res_fwd_reg, res_side_reg, res_up_reg;

    // Output register
    logic                 out_valid_reg;
    logic [OW-1:0]        out_fwd_reg, out_side_reg, out_up_reg;

    logic                 acc;
    logic [CW:0]          col_inc;
    logic [RW:0]          row_inc;
    logic                 col_wrap;

    logic [PXW-1:0]       span;
    logic [PXW-1:0]       pdiff;
    logic [2*PXW-1:0]     norm_num;
    logic [PXW:0]         rem2;
    logic [PXW:0]         q_round;
    logic                 round_up;
    logic [PXW-1:0]       d_fix;

    logic signed [DW-1:0] dc, dr, mul_a;
    logic signed [drp_pkg::BASE_W:0] mul_b;
    logic [MW-1:0]        mag;
    logic [MW:0]          num_rnd;

    logic                 div_start;
    logic [DVP-1:0]       div_dividend;
    logic [PXW-1:0]       div_divisor;
    logic                 div_done;
    logic [DVP-1:0]       div_quot;
    logic [PXW-1:0]       div_rem;

    logic                 flip;
    logic signed [SW-1:0] qv, sum, offs;
    logic                 fits;
    logic [OW-1:0]        sat;

    assign acc = in_valid && cmd.take;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= drp_pkg::RST_IMAGE_WIDTH;
            focal_length_reg <= drp_pkg::RST_FOCAL_LENGTH;
            center_col_reg   <= drp_pkg::RST_CENTER_COL;
            center_row_reg   <= drp_pkg::RST_CENTER_ROW;
            baseline_reg     <= drp_pkg::RST_BASELINE;
            offset_fwd_reg   <= drp_pkg::RST_OFFSET_FWD;
            offset_side_reg  <= drp_pkg::RST_OFFSET_SIDE;
            offset_up_reg    <= drp_pkg::RST_OFFSET_UP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                drp_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[drp_pkg::IMG_W_W-1:0];
                drp_pkg::REG_FOCAL_LENGTH:
                    focal_length_reg <= cfg_data[drp_pkg::CAM_W-1:0];
                drp_pkg::REG_CENTER_COL:
                    center_col_reg <= cfg_data[drp_pkg::CAM_W-1:0];
                drp_pkg::REG_CENTER_ROW:
                    center_row_reg <= cfg_data[drp_pkg::CAM_W-1:0];
                drp_pkg::REG_BASELINE:
                    baseline_reg <= cfg_data[drp_pkg::BASE_W-1:0];
                drp_pkg::REG_OFFSET_FWD:  offset_fwd_reg  <= cfg_data[OFW-1:0];
                drp_pkg::REG_OFFSET_SIDE: offset_side_reg <= cfg_data[OFW-1:0];
                drp_pkg::REG_OFFSET_UP:   offset_up_reg   <= cfg_data[OFW-1:0];
                default: ;
            endcase
        end
    end

    // Advance the raster position; a width of zero wraps every pixel
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + (CW+1)'(1);
        row_inc  = {1'b0, row_reg} + (RW+1)'(1);
        col_wrap = (CMPW'(col_inc) >= CMPW'(image_width_reg))
                   || (col_inc >= (CW+1)'(MAX_WIDTH));
        if (in_frame_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_wrap)
        begin
            col_next = '0;
            row_next = (row_inc >= (RW+1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    // Track range on gather pixels, reset it at a convert frame end, and raster position on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= drp_pkg::PIX_MAX;
            highest_reg <= drp_pkg::PIX_MIN;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!in_mode)
            begin
                if (in_disparity < lowest_reg)
                begin
                    lowest_reg <= in_disparity;
                end
                if (in_disparity > highest_reg)
                begin
                    highest_reg <= in_disparity;
                end
            end
            else if (in_frame_end)
            begin
                lowest_reg  <= drp_pkg::PIX_MAX;
                highest_reg <= drp_pkg::PIX_MIN;
            end
        end
    end

    // Capture a convert pixel with the range and position it sees
    always_ff @(posedge clk)
    begin
        if (acc && in_mode)
        begin
            pix_w_reg <= in_disparity;
            lo_w_reg  <= lowest_reg;
            hi_w_reg  <= highest_reg;
            col_w_reg <= col_reg;
            row_w_reg <= row_reg;
        end
    end

    // Normalization operands and rounding
    always_comb
    begin
        span     = hi_w_reg - lo_w_reg;
        pdiff    = pix_w_reg - lo_w_reg;
        norm_num = {pdiff, {PXW{1'b0}}} - {{PXW{1'b0}}, pdiff};
        rem2     = {div_rem, 1'b0};
        round_up = (rem2 > {1'b0, span}) || ((rem2 == {1'b0, span}) && div_quot[0]);
        q_round  = {1'b0, div_quot[PXW-1:0]} + (PXW+1)'(round_up);
        d_fix    = ((hi_w_reg > lo_w_reg) && (pix_w_reg > lo_w_reg)) ? drp_pkg::PIX_MAX
                                                                     : drp_pkg::PIX_MIN;
    end

    // Load the normalized disparity
    always_ff @(posedge clk)
    begin
        if (cmd.norm_fix)
        begin
            d_reg <= d_fix;
        end
        else if (cmd.norm_load)
        begin
            d_reg <= q_round[PXW] ? drp_pkg::PIX_MAX : q_round[PXW-1:0];
        end
    end

    // Select multiplier operands per axis
    always_comb
    begin
        dc    = $signed(DW'({col_w_reg, 8'h00})) - $signed(DW'(center_col_reg));
        dr    = $signed(DW'({row_w_reg, 8'h00})) - $signed(DW'(center_row_reg));
        mul_b = $signed({1'b0, baseline_reg});
        case (cmd.axis)
            drp_pkg::AXIS_FWD:  mul_a = $signed(DW'(focal_length_reg));
            drp_pkg::AXIS_SIDE: mul_a = dc;
            drp_pkg::AXIS_UP:   mul_a = dr;
            default:            mul_a = '0;
        endcase
    end

    // Form the rounded dividend: (|p| + 128*d) / 256, then divide by d
    always_comb
    begin
        mag     = prod_reg[MW-1] ? MW'(-prod_reg) : MW'(prod_reg);
        num_rnd = {1'b0, mag} + (MW+1)'({d_reg, 7'b0});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= MW'(mul_a * mul_b);
        end
        if (cmd.prep)
        begin
            dvd_reg <= num_rnd[MW:8];
            neg_reg <= prod_reg[MW-1];
        end
    end

    // Share the divider between normalization and the axes
    assign div_start    = cmd.norm_start || cmd.div_start;
    assign div_dividend = cmd.norm_start ? DVP'(norm_num) : DVP'(dvd_reg);
    assign div_divisor  = cmd.norm_start ? span : d_reg;

    drp_div #(
        .DIVIDEND_W (DVP)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sign, add offset, saturate
    always_comb
    begin
        flip = neg_reg ^ (cmd.axis != drp_pkg::AXIS_FWD);
        qv   = $signed({2'b00, div_quot[DVW-1:0]});
        case (cmd.axis)
            drp_pkg::AXIS_FWD:
                offs = $signed({{(SW-OFW){offset_fwd_reg[OFW-1]}}, offset_fwd_reg});
            drp_pkg::AXIS_SIDE:
                offs = $signed({{(SW-OFW){offset_side_reg[OFW-1]}}, offset_side_reg});
            drp_pkg::AXIS_UP:
                offs = $signed({{(SW-OFW){offset_up_reg[OFW-1]}}, offset_up_reg});
            default:
                offs = '0;
        endcase
        sum  = flip ? (offs - qv) : (offs + qv);
        fits = (&sum[SW-1:OW-1]) || !(|sum[SW-1:OW-1]);
        if (fits)
        begin
            sat = sum[OW-1:0];
        end
        else if (sum[SW-1])
        begin
            sat = {1'b1, {(OW-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(OW-1){1'b1}}};
        end
    end

    // Hold finished axes
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (cmd.axis)
                drp_pkg::AXIS_FWD:  res_fwd_reg  <= sat;
                drp_pkg::AXIS_SIDE: res_side_reg <= sat;
                drp_pkg::AXIS_UP:   res_up_reg   <= sat;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_fwd_reg  <= res_fwd_reg;
            out_side_reg <= res_side_reg;
            out_up_reg   <= res_up_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_fwd   = $signed(out_fwd_reg);
    assign out_side  = $signed(out_side_reg);
    assign out_up    = $signed(out_up_reg);

    // Report status
    always_comb
    begin
        sts              = '0;
        sts.norm_trivial = (hi_w_reg <= lo_w_reg) || (pix_w_reg <= lo_w_reg)
                           || (pix_w_reg >= hi_w_reg);
        sts.div_done     = div_done;
        sts.d_zero       = (d_reg == drp_pkg::PIX_MIN);
        sts.out_free     = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// ===== sv/disparity_to_point_reprojection_unit.sv =====
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_unit: stereo disparity to 3-D points
// Min-max normalizes a disparity frame and reprojects each pixel to a point.
// ----------------------------------------------------------------------------
// Usage:
//   Stream every frame twice over the pixel channel in raster order: first
//   with mode 0 (range gather), then with mode 1 (convert). Set frame_end on
//   the last pixel of each pass. Each convert pixel whose normalized value is
//   nonzero yields one request on the point channel (forward, side, up in
//   meters Q.16, saturated to 24 bits). Write cfg_we/cfg_index/cfg_data idle.
// Sequencing:
//   Gather pixels are taken back to back while idle. A convert pixel
//   normalizes directly at or outside the range ends, else with a divide;
//   a nonzero one then multiplies and divides for forward, side and up,
//   and output stalls hold the point. The shared divider does 8 steps of 4 bits.
// Reset and stall:
//   Reset loads the register defaults, clears the raster position and the
//   gathered range. A finished point waits in the output register; the
//   next pixel is taken meanwhile, and only a second point waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reprojection_unit #(
    parameter int MAX_WIDTH  = drp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = drp_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [drp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [drp_pkg::CFG_DATA_W-1:0]  cfg_data,
    drp_in_if.sink                               in,
    drp_out_if.source                            out
);

    drp_pkg::cmd_t    cmd;
    drp_pkg::status_t sts;

    assign in.ready = cmd.take;

    drp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_mode  (in.mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    drp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in.valid),
        .in_mode      (in.mode),
        .in_disparity (in.disparity),
        .in_frame_end (in.frame_end),
        .out_ready    (out.ready),
        .out_valid    (out.valid),
        .out_fwd      (out.point_fwd),
        .out_side     (out.point_side),
        .out_up       (out.point_up),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire
